/* sv/rtbcv_pkg.sv */
// Package for the tile border color vote block: widths, class codes,
// classification thresholds and the pixel classifier function.
// Depends on nothing; used by the channel interfaces, the top level and the checker.
package rtbcv_pkg;

   // Field and storage widths
   localparam int COLOR_W     = 8;
   localparam int CLASS_W     = 4;
   localparam int POS_W       = 3;
   localparam int COUNT_W     = 6;
   localparam int NUM_CLASSES = 11;
   localparam int ADDR_W      = $clog2(NUM_CLASSES);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Color classes
   localparam logic [CLASS_W-1:0] CLS_BLACK  = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_WHITE  = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_GRAY   = 4'd2;
   localparam logic [CLASS_W-1:0] CLS_YELLOW = 4'd3;
   localparam logic [CLASS_W-1:0] CLS_ORANGE = 4'd4;
   localparam logic [CLASS_W-1:0] CLS_RED    = 4'd5;
   localparam logic [CLASS_W-1:0] CLS_GREEN  = 4'd6;
   localparam logic [CLASS_W-1:0] CLS_BLUE   = 4'd7;
   localparam logic [CLASS_W-1:0] CLS_BROWN  = 4'd8;
   localparam logic [CLASS_W-1:0] CLS_PURPLE = 4'd9;
   localparam logic [CLASS_W-1:0] CLS_PINK   = 4'd10;
   localparam logic [CLASS_W-1:0] CLS_LAST   = CLS_PINK;

   // Thresholds
   localparam logic [COLOR_W-1:0] DARK_LIM    = 8'd20;
   localparam logic [COLOR_W-1:0] BRIGHT_LIM  = 8'd230;
   localparam logic [9:0]         GRAY_SPREAD = 10'd45;
   localparam logic [COLOR_W-1:0] WARM_RED    = 8'd200;
   localparam logic [COLOR_W-1:0] LOW_CHAN    = 8'd30;
   localparam logic [COLOR_W-1:0] YELLOW_GRN  = 8'd160;
   localparam logic [8:0]         RED_SPREAD  = 9'd200;
   localparam logic [COLOR_W-1:0] BROWN_GAP   = 8'd15;
   localparam logic [COLOR_W-1:0] PURPLE_LIM  = 8'd100;

   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [COUNT_W-1:0] count_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      abs_diff = (a > b) ? a - b : b - a;
   endfunction

   // Fixed-threshold classifier, first matching rule wins
   function automatic class_type classify(input logic [COLOR_W-1:0] r,
                                          input logic [COLOR_W-1:0] g,
                                          input logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] d_rg;
      logic [COLOR_W-1:0] d_rb;
      logic [COLOR_W-1:0] d_gb;
      logic [8:0]         sum2;
      logic [9:0]         sum3;
      d_rg = abs_diff(r, g);
      d_rb = abs_diff(r, b);
      d_gb = abs_diff(g, b);
      sum2 = {1'b0, d_rg} + {1'b0, d_rb};
      sum3 = {1'b0, sum2} + {2'b00, d_gb};
      if (r < DARK_LIM && g < DARK_LIM && b < DARK_LIM)
         classify = CLS_BLACK;
      else if (r > BRIGHT_LIM && g > BRIGHT_LIM && b > BRIGHT_LIM)
         classify = CLS_WHITE;
      else if (sum3 < GRAY_SPREAD)
         classify = CLS_GRAY;
      else if (r > WARM_RED && g > LOW_CHAN && b < LOW_CHAN)
         classify = (g > YELLOW_GRN) ? CLS_YELLOW : CLS_ORANGE;
      else if (sum2 > RED_SPREAD && g < LOW_CHAN && b < LOW_CHAN)
         classify = CLS_RED;
      else if (g >= r && g > b)
         classify = CLS_GREEN;
      else if (b > r && b > g && g > r)
         classify = CLS_BLUE;
      else if (r > g) begin
         if (g > b && d_gb > BROWN_GAP)
            classify = CLS_BROWN;
         else if (r < PURPLE_LIM)
            classify = CLS_PURPLE;
         else
            classify = CLS_PINK;
      end else
         classify = CLS_BLACK;
   endfunction

endpackage

/* sv/rtbcv_chan_if.sv */
// Valid/ready channel interfaces: border pixel requests and tile color responses.
// Depends on rtbcv_pkg.
interface rtbcv_req_if;
   import rtbcv_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic               first_of_tile;
   logic               last_of_tile;
   logic [POS_W-1:0]   tile_row;
   logic [POS_W-1:0]   tile_col;

   modport source (output valid, red, green, blue, first_of_tile, last_of_tile,
                   tile_row, tile_col, input ready);
   modport sink   (input valid, red, green, blue, first_of_tile, last_of_tile,
                   tile_row, tile_col, output ready);
endinterface

interface rtbcv_rsp_if;
   import rtbcv_pkg::*;
   logic             valid;
   logic             ready;
   class_type        tile_color;
   logic [POS_W-1:0] out_row;
   logic [POS_W-1:0] out_col;

   modport source (output valid, tile_color, out_row, out_col, input ready);
   modport sink   (input valid, tile_color, out_row, out_col, output ready);
endinterface

/* sv/rtbcv_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rtbcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/rgb_tile_border_color_vote.sv */
// Tile border color vote: classifies border pixels and reports the leading class per tile.
// Tile results are registered after stage 1; one pixel per cycle while results do not stall.
// Throughput is set by the vote RAM read-modify-write, with one-entry forwarding.
// Synchronous reset clears the per-entry valid bits (all counts read as zero), the leader,
// the pipeline and the output register; no clearing pass is needed.
module rgb_tile_border_color_vote (
   input logic        clock,
   input logic        reset,
   rtbcv_req_if.sink  req_if,
   rtbcv_rsp_if.source rsp_if
);
   import rtbcv_pkg::*;

   // Stage 0 classify
   class_type rd_class;
   logic      req_xfer;

   // Stage 1 registers
   logic             s1_valid_ff;
   class_type        s1_class_ff;
   logic             s1_first_ff;
   logic             s1_last_ff;
   logic [POS_W-1:0] s1_row_ff;
   logic [POS_W-1:0] s1_col_ff;

   // Vote state
   logic [NUM_CLASSES-1:0] vote_vld_ff, vote_vld_in;
   class_type              leader_ff, leader_in;
   count_type              leader_cnt_ff, leader_cnt_in;
   count_type              ram_rd_data;

   // Forwarding of the most recent write; held while stage 1 stalls
   logic      fwd_valid_ff;
   class_type fwd_class_ff;
   count_type fwd_count_ff;

   // Output register
   logic             rsp_valid_ff;
   class_type        rsp_color_ff;
   logic [POS_W-1:0] rsp_row_ff;
   logic [POS_W-1:0] rsp_col_ff;

   logic      out_free;
   logic      s1_go;
   count_type base_count;
   count_type new_count;

   assign rd_class = classify(req_if.red, req_if.green, req_if.blue);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s1_go    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_if.ready = !s1_valid_ff || s1_go;
   assign req_xfer = req_if.valid && req_if.ready;

   rtbcv_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_CLASSES)
   ) u_vote_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_class_ff[ADDR_W-1:0]),
      .wr_data (new_count),
      .rd_en   (req_xfer),
      .rd_addr (rd_class[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Count before this pixel: cleared tile, forwarded write, stored entry or zero
   always_comb begin
      if (s1_first_ff)
         base_count = '0;
      else if (fwd_valid_ff && fwd_class_ff == s1_class_ff)
         base_count = fwd_count_ff;
      else if (vote_vld_ff[s1_class_ff[ADDR_W-1:0]])
         base_count = ram_rd_data;
      else
         base_count = '0;
      new_count = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 1'b1;
   end

   // Leader update; the leader's own count is kept beside it
   always_comb begin
      class_type cur_leader;
      count_type cur_cnt;
      cur_leader  = s1_first_ff ? CLS_BLACK : leader_ff;
      cur_cnt     = s1_first_ff ? '0 : leader_cnt_ff;
      vote_vld_in = s1_first_ff ? '0 : vote_vld_ff;
      vote_vld_in[s1_class_ff[ADDR_W-1:0]] = 1'b1;
      leader_in     = cur_leader;
      leader_cnt_in = cur_cnt;
      if (s1_class_ff == cur_leader)
         leader_cnt_in = new_count;
      else if (new_count > cur_cnt) begin
         leader_in     = s1_class_ff;
         leader_cnt_in = new_count;
      end
   end

   // Pipeline, vote state and forwarding registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         vote_vld_ff   <= '0;
         leader_ff     <= CLS_BLACK;
         leader_cnt_ff <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer)
            s1_valid_ff <= 1'b1;
         else if (s1_go)
            s1_valid_ff <= 1'b0;
         if (s1_go)
            fwd_valid_ff <= 1'b1;
         if (s1_go) begin
            vote_vld_ff   <= vote_vld_in;
            leader_ff     <= leader_in;
            leader_cnt_ff <= leader_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_class_ff <= rd_class;
         s1_first_ff <= req_if.first_of_tile;
         s1_last_ff  <= req_if.last_of_tile;
         s1_row_ff   <= req_if.tile_row;
         s1_col_ff   <= req_if.tile_col;
      end
      if (s1_go) begin
         fwd_class_ff <= s1_class_ff;
         fwd_count_ff <= new_count;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (s1_go && s1_last_ff)
         rsp_valid_ff <= 1'b1;
      else if (rsp_if.ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         rsp_color_ff <= leader_in;
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= s1_col_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.tile_color = rsp_color_ff;
   assign rsp_if.out_row    = rsp_row_ff;
   assign rsp_if.out_col    = rsp_col_ff;
endmodule

/* sv/rtbcv_checker.sv */
// Port-level checker for the tile border color vote block, bound to the top level.
// Depends on rtbcv_pkg and rgb_tile_border_color_vote.
module rtbcv_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rtbcv_pkg::class_type      rsp_color,
   input logic [rtbcv_pkg::POS_W-1:0] rsp_row,
   input logic [rtbcv_pkg::POS_W-1:0] rsp_col
);
   import rtbcv_pkg::*;

   // Reset empties the result register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A fresh result follows a last-pixel transfer
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result without a last-pixel transfer");

   // A stalled result holds
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color) &&
                                  $stable(rsp_row) && $stable(rsp_col))
      else $error("stalled result changed");

   // Only real classes are reported
   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_color <= CLS_LAST)
      else $error("tile color out of range");
endmodule

bind rgb_tile_border_color_vote rtbcv_checker u_rtbcv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_last  (req_if.last_of_tile),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_color (rsp_if.tile_color),
   .rsp_row   (rsp_if.out_row),
   .rsp_col   (rsp_if.out_col)
);
